### sv/hdir_pkg.sv
// ----------------------------------------------------------------------------
// HID descriptor item repair package
// Shared types and constants for the descriptor item repair unit.
// ----------------------------------------------------------------------------
package hdir_pkg;

  // Byte that opens a long item.
  localparam logic [7:0] LongPrefix = 8'hFE;

  // Item types in bits 3..2 of a short item prefix.
  localparam logic [1:0] TypeMain   = 2'd0;
  localparam logic [1:0] TypeGlobal = 2'd1;
  localparam logic [1:0] TypeLocal  = 2'd2;

  // Item tags in bits 7..4 of a short item prefix.
  localparam logic [3:0] TagUsage       = 4'd0;
  localparam logic [3:0] TagUsagePage   = 4'd0;
  localparam logic [3:0] TagReportCount = 4'd9;
  localparam logic [3:0] TagInput       = 4'd8;
  localparam logic [3:0] TagOutput      = 4'd9;
  localparam logic [3:0] TagFeature     = 4'd11;

  // Prefixes of inserted items.
  localparam logic [7:0] PfxUsagePage1   = 8'h05;
  localparam logic [7:0] PfxUsagePage2   = 8'h06;
  localparam logic [7:0] PfxReportCount1 = 8'h95;
  localparam logic [7:0] PfxReportCount2 = 8'h96;
  localparam logic [7:0] PfxReportCount4 = 8'h97;

  // Emit buffer: up to five inserted bytes plus the passed-through byte.
  localparam int unsigned MaxInsert = 5;
  localparam int unsigned BufBytes  = MaxInsert + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_REPAIR_ENABLE = 2'd0,
    REG_USAGE_PAGE    = 2'd1,
    REG_RPT_COUNT     = 2'd2
  } cfg_reg_e;

  // Parser position inside a long item header.
  typedef enum logic [1:0] {
    LP_PREFIX = 2'd0,
    LP_SIZE   = 2'd1,
    LP_TAG    = 2'd2
  } long_phase_e;

  // Kind of insertion made in front of a prefix.
  typedef enum logic [2:0] {
    INS_NONE,
    INS_PAGE1,
    INS_PAGE2,
    INS_COUNT1,
    INS_COUNT2,
    INS_COUNT4
  } insert_e;

  // Configuration register contents.
  typedef struct packed {
    logic        repair_enable;
    logic [15:0] usage_page;
    logic [31:0] count_value;
  } cfg_t;

  // One parsed request: bytes to emit, lowest byte first.
  typedef struct packed {
    logic [2:0]            ins_cnt;
    logic [8*BufBytes-1:0] bytes;
    logic                  last;
  } job_t;

endpackage

### sv/hdir_in_if.sv
// ----------------------------------------------------------------------------
// HID descriptor input channel
// Valid/ready channel carrying one raw descriptor byte per request.
// ----------------------------------------------------------------------------
interface hdir_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       in_last;

  modport source (output valid, output desc_byte, output in_last, input ready);
  modport sink   (input valid, input desc_byte, input in_last, output ready);
endinterface

### sv/hdir_out_if.sv
// ----------------------------------------------------------------------------
// HID descriptor output channel
// Valid/ready channel carrying one repaired descriptor byte per request.
// ----------------------------------------------------------------------------
interface hdir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       run_end;

  modport source (output valid, output out_byte, output out_last, output run_end,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input run_end,
                  output ready);
endinterface

### sv/hdir_parser.sv
// ----------------------------------------------------------------------------
// HID descriptor item parser
// Tracks item boundaries and builds the byte sequence for each input byte.
// ----------------------------------------------------------------------------
module hdir_parser
  import hdir_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] desc_byte_i,
  input  logic       in_last_i,
  input  cfg_t       cfg_i,
  output job_t       job_o
);

  long_phase_e phase_q, phase_d;
  logic [7:0]  data_left_q, data_left_d;
  logic        page_done_q, page_done_d;
  logic        count_done_q, count_done_d;
  insert_e     ins_kind;

  logic [3:0] tag;
  logic [1:0] itype;
  logic [1:0] sz;

  assign tag   = desc_byte_i[7:4];
  assign itype = desc_byte_i[3:2];
  assign sz    = desc_byte_i[1:0];

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= LP_PREFIX;
      data_left_q  <= '0;
      page_done_q  <= 1'b0;
      count_done_q <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      data_left_q  <= data_left_d;
      page_done_q  <= page_done_d;
      count_done_q <= count_done_d;
    end
  end

  // Next state and the insertion decision for the current byte.
  always_comb begin
    phase_d      = phase_q;
    data_left_d  = data_left_q;
    page_done_d  = page_done_q;
    count_done_d = count_done_q;
    ins_kind     = INS_NONE;

    unique case (phase_q)
      LP_SIZE: begin
        data_left_d = desc_byte_i;
        phase_d     = LP_TAG;
      end
      LP_TAG: begin
        phase_d = LP_PREFIX;
      end
      default: begin
        if (data_left_q != 8'd0) begin
          data_left_d = data_left_q - 8'd1;
        end else if (desc_byte_i == LongPrefix) begin
          phase_d = LP_SIZE;
        end else begin
          data_left_d = (sz == 2'd3) ? 8'd4 : {6'd0, sz};

          // A usage ahead of any usage page gets a usage page in front.
          if (!page_done_q && tag == TagUsage) begin
            if (itype == TypeGlobal) begin
              page_done_d = 1'b1;
            end else if (itype == TypeLocal) begin
              page_done_d = 1'b1;
              if (cfg_i.repair_enable) begin
                ins_kind = (cfg_i.usage_page[15:8] == 8'd0) ? INS_PAGE1 : INS_PAGE2;
              end
            end
          end

          // The first input, output or feature item with no report count gets one ahead.
          if (!count_done_q) begin
            if (itype == TypeGlobal && tag == TagReportCount) begin
              count_done_d = 1'b1;
            end else if (itype == TypeMain &&
                         (tag == TagInput || tag == TagOutput || tag == TagFeature)) begin
              count_done_d = 1'b1;
              if (cfg_i.repair_enable) begin
                if (cfg_i.count_value[31:8] == 24'd0) begin
                  ins_kind = INS_COUNT1;
                end else if (cfg_i.count_value[31:16] == 16'd0) begin
                  ins_kind = INS_COUNT2;
                end else begin
                  ins_kind = INS_COUNT4;
                end
              end
            end
          end
        end
      end
    endcase

    // The final byte of a descriptor restarts the parse.
    if (in_last_i) begin
      phase_d      = LP_PREFIX;
      data_left_d  = '0;
      page_done_d  = 1'b0;
      count_done_d = 1'b0;
    end
  end

  // Lay out the emitted bytes, first byte in the low lane.
  always_comb begin
    job_o.last  = in_last_i;
    job_o.bytes = '0;
    unique case (ins_kind)
      INS_PAGE1: begin
        job_o.ins_cnt     = 3'd2;
        job_o.bytes[23:0] = {desc_byte_i, cfg_i.usage_page[7:0], PfxUsagePage1};
      end
      INS_PAGE2: begin
        job_o.ins_cnt     = 3'd3;
        job_o.bytes[31:0] = {desc_byte_i, cfg_i.usage_page, PfxUsagePage2};
      end
      INS_COUNT1: begin
        job_o.ins_cnt     = 3'd2;
        job_o.bytes[23:0] = {desc_byte_i, cfg_i.count_value[7:0], PfxReportCount1};
      end
      INS_COUNT2: begin
        job_o.ins_cnt     = 3'd3;
        job_o.bytes[31:0] = {desc_byte_i, cfg_i.count_value[15:0], PfxReportCount2};
      end
      INS_COUNT4: begin
        job_o.ins_cnt     = 3'd5;
        job_o.bytes[47:0] = {desc_byte_i, cfg_i.count_value, PfxReportCount4};
      end
      default: begin
        job_o.ins_cnt    = 3'd0;
        job_o.bytes[7:0] = desc_byte_i;
      end
    endcase
  end

endmodule

### sv/hdir_emitter.sv
// ----------------------------------------------------------------------------
// HID descriptor byte emitter
// Holds one parsed request and sends its bytes one per cycle when not stalled.
// ----------------------------------------------------------------------------
module hdir_emitter
  import hdir_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  hdir_out_if.source desc_out
);

  logic                  valid_q;
  logic [2:0]            cnt_q;
  logic [8*BufBytes-1:0] bytes_q;
  logic                  last_q;
  logic                  load;
  logic                  out_fire;
  logic                  final_byte;

  assign final_byte  = (cnt_q == 3'd0);
  assign out_fire    = valid_q && desc_out.ready;
  assign job_ready_o = !valid_q || (desc_out.ready && final_byte);
  assign load        = job_valid_i && job_ready_o;

  // Output valid and the count of inserted bytes still ahead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      cnt_q   <= job_i.ins_cnt;
    end else if (out_fire) begin
      if (final_byte) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  // Byte buffer shifts down by one byte per request sent.
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= job_i.bytes;
      last_q  <= job_i.last;
    end else if (out_fire && !final_byte) begin
      bytes_q <= {8'd0, bytes_q[8*BufBytes-1:8]};
    end
  end

  assign desc_out.valid    = valid_q;
  assign desc_out.out_byte = bytes_q[7:0];
  assign desc_out.out_last = final_byte && last_q;
  assign desc_out.run_end  = final_byte;

endmodule

### sv/hid_descriptor_item_repair_unit.sv
// ----------------------------------------------------------------------------
// HID descriptor item repair unit
// Passes a HID report descriptor through byte by byte and inserts a missing
// usage page or report count item where the descriptor needs one.
// ----------------------------------------------------------------------------
// Usage:
// Descriptor bytes enter on desc_in, one per request, with in_last on the
// final byte of a descriptor. Repaired bytes leave on desc_out; run_end marks
// the last byte produced for an input byte, which is always the copy of that
// input byte, and out_last repeats in_last on that copy.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the unit is idle: repair enable, usage page and report count.
// The first output byte is registered and appears in the cycle after its
// input byte is accepted. Plain bytes that need no insertion flow at one per
// cycle while the receiver is ready; a byte with an insertion holds the output
// register until its inserted item of 2, 3 or 5 bytes and its own copy have
// gone out, and input stalls meanwhile. The next byte is taken while the last
// byte of the current request is being handed over.
// Reset clears the parser state, the configuration and the output valid flag.
// When the receiver stalls, the output byte holds and input backs up after
// one buffered request.
// ----------------------------------------------------------------------------
module hid_descriptor_item_repair_unit
  import hdir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hdir_in_if.sink     desc_in,
  hdir_out_if.source  desc_out,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t job;
  logic in_ready;
  logic in_fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REPAIR_ENABLE: cfg_q.repair_enable <= cfg_data_i[0];
        REG_USAGE_PAGE:    cfg_q.usage_page    <= cfg_data_i[15:0];
        REG_RPT_COUNT:     cfg_q.count_value   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign desc_in.ready = in_ready;
  assign in_fire       = desc_in.valid && in_ready;

  hdir_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .desc_byte_i (desc_in.desc_byte),
    .in_last_i   (desc_in.in_last),
    .cfg_i       (cfg_q),
    .job_o       (job)
  );

  hdir_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (desc_in.valid),
    .job_ready_o (in_ready),
    .job_i       (job),
    .desc_out    (desc_out)
  );

endmodule
